### hw/rtl/slice_min_max_gray_normalize_assert.svh
// ----------------------------------------------------------------------------
// slice_min_max_gray_normalize_assert.svh
// assertion macros shared by the gray normalize modules
// ----------------------------------------------------------------------------
`ifndef SLICE_MIN_MAX_GRAY_NORMALIZE_ASSERT_SVH
`define SLICE_MIN_MAX_GRAY_NORMALIZE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define SMMG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define SMMG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/smmg_pkg.sv
// ----------------------------------------------------------------------------
// smmg_pkg
// types and constants of the slice min-max gray normalize block
// ----------------------------------------------------------------------------
package smmg_pkg;

  localparam int DEF_MAX_WIDTH  = 512;
  localparam int DEF_MAX_HEIGHT = 512;

  localparam int SAMPLE_W   = 16;
  localparam int COORD_W    = 9;
  localparam int DIM_W      = 10;
  localparam int GRAY_W     = 8;
  localparam int PROD_W     = SAMPLE_W + GRAY_W;
  localparam int STEP_W     = $clog2(GRAY_W);
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7fff;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;
  localparam logic [GRAY_W-1:0]          GRAY_MAX   = 8'hff;

  localparam logic [DIM_W-1:0]    WIDTH_RST    = 10'd512;
  localparam logic [DIM_W-1:0]    HEIGHT_RST   = 10'd512;
  localparam logic [SAMPLE_W-1:0] MAX_DIFF_RST = 16'd1;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_LOAD  = 2'd1,
    OP_READ  = 2'd2
  } opcode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH     = 2'd0,
    REG_IMAGE_HEIGHT    = 2'd1,
    REG_DIFFERENCE_MODE = 2'd2,
    REG_MAX_DIFF        = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic take;
    logic prep;
    logic mul;
    logic init;
    logic step;
    logic load_out;
  } smmg_cmd_t;

  typedef struct packed {
    logic rd_item;
    logic out_free;
  } smmg_sts_t;

endpackage

### hw/rtl/smmg_ctrl.sv
// ----------------------------------------------------------------------------
// smmg_ctrl
// sequencer for item acceptance, gray scaling and the serial divider
// ----------------------------------------------------------------------------
`include "slice_min_max_gray_normalize_assert.svh"

module smmg_ctrl import smmg_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  smmg_sts_t sts,
  output smmg_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_MUL,
    S_INIT,
    S_DIV,
    S_FIN
  } state_t;

  state_t             state_r, state_nxt;
  logic [STEP_W-1:0]  cnt_r, cnt_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    cmd          = '0;
    cmd.take     = in_valid && in_ready;
    cmd.prep     = (state_r == S_FETCH);
    cmd.mul      = (state_r == S_MUL);
    cmd.init     = (state_r == S_INIT);
    cmd.step     = (state_r == S_DIV);
    cmd.load_out = (state_r == S_FIN) && sts.out_free;
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      S_IDLE: begin
        if (cmd.take && sts.rd_item) begin
          state_nxt = S_FETCH;
        end
      end
      S_FETCH: state_nxt = S_MUL;
      S_MUL:   state_nxt = S_INIT;
      S_INIT: begin
        state_nxt = S_DIV;
        cnt_nxt   = '0;
      end
      S_DIV: begin
        cnt_nxt = cnt_r + STEP_W'(1);
        if (cnt_r == STEP_W'(GRAY_W - 1)) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (sts.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  `SMMG_ASSERT_NEXT(a_read_starts, cmd.take && sts.rd_item, state_r == S_FETCH, "read item not started")
  `SMMG_ASSERT_NEXT(a_div_length, state_r == S_INIT, cnt_r == '0 && state_r == S_DIV, "divider not primed")
  `SMMG_ASSERT_NEXT(a_fin_exit, cmd.load_out, state_r == S_IDLE, "result handed over without release")

endmodule

### hw/rtl/smmg_dp.sv
// ----------------------------------------------------------------------------
// smmg_dp
// pixel store, running statistics, gray scaling and serial divider
// ----------------------------------------------------------------------------
`include "slice_min_max_gray_normalize_assert.svh"

module smmg_dp import smmg_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  smmg_cmd_t                  cmd,
  output smmg_sts_t                  sts,
  input  logic [1:0]                 in_opcode,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  input  logic [COORD_W-1:0]         in_row,
  input  logic [COORD_W-1:0]         in_col,
  input  logic                       cfg_valid,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [GRAY_W-1:0]          out_gray
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [DIM_W-1:0]           img_w_r, img_h_r;
  logic                       diff_mode_r;
  logic [SAMPLE_W-1:0]        max_diff_r;

  logic [DIM_W-1:0]           eff_w, eff_h, src_row, row_sel;
  logic                       in_range;
  logic [31:0]                addr_full;
  logic [AW-1:0]              mem_addr;
  logic                       do_load, do_read, do_clear;

  logic [SAMPLE_W-1:0]        mem [DEPTH];
  logic [SAMPLE_W-1:0]        rdata_r;
  logic signed [SAMPLE_W-1:0] min_r, max_r;

  logic signed [SAMPLE_W:0]   v_ext, d_ext, span_ext, mag_ext;
  logic [SAMPLE_W-1:0]        num_nxt, den_nxt;
  logic [SAMPLE_W-1:0]        num_r, den_r;
  logic [PROD_W-1:0]          prod_r;
  logic                       sat_r;
  logic [SAMPLE_W-1:0]        rem_r;
  logic [GRAY_W-1:0]          quo_r;
  logic [SAMPLE_W:0]          trial;
  logic                       trial_ge;

  logic                       out_valid_r;
  logic [GRAY_W-1:0]          out_gray_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_w_r     <= WIDTH_RST;
      img_h_r     <= HEIGHT_RST;
      diff_mode_r <= 1'b0;
      max_diff_r  <= MAX_DIFF_RST;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_IMAGE_WIDTH:     img_w_r     <= cfg_data[DIM_W-1:0];
        REG_IMAGE_HEIGHT:    img_h_r     <= cfg_data[DIM_W-1:0];
        REG_DIFFERENCE_MODE: diff_mode_r <= cfg_data[0];
        REG_MAX_DIFF:        max_diff_r  <= cfg_data[SAMPLE_W-1:0];
        default: ;
      endcase
    end
  end

  // address decode
  assign eff_w = (32'(img_w_r) > 32'(MAX_WIDTH))  ? DIM_W'(MAX_WIDTH)  : img_w_r;
  assign eff_h = (32'(img_h_r) > 32'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : img_h_r;
  assign in_range = ({1'b0, in_col} < eff_w) && ({1'b0, in_row} < eff_h);
  assign src_row  = eff_h - DIM_W'(1) - {1'b0, in_row};
  assign row_sel  = (in_opcode == OP_READ) ? src_row : {1'b0, in_row};
  assign addr_full = 32'(row_sel) * 32'(MAX_WIDTH) + 32'(in_col);
  assign mem_addr  = addr_full[AW-1:0];

  assign do_load  = cmd.take && (in_opcode == OP_LOAD) && in_range;
  assign do_read  = cmd.take && sts.rd_item;
  assign do_clear = cmd.take && (in_opcode == OP_CLEAR);

  assign sts.rd_item  = (in_opcode == OP_READ) && in_range;
  assign sts.out_free = !out_valid_r || out_ready;

  // pixel store
  always_ff @(posedge clk) begin
    if (do_load) begin
      mem[mem_addr] <= in_sample;
    end
    if (do_read) begin
      rdata_r <= mem[mem_addr];
    end
  end

  // running statistics
  always_ff @(posedge clk) begin
    if (!rst_n || do_clear) begin
      min_r <= SAMPLE_MAX;
      max_r <= SAMPLE_MIN;
    end else if (do_load) begin
      if (in_sample < min_r) begin
        min_r <= in_sample;
      end
      if (in_sample > max_r) begin
        max_r <= in_sample;
      end
    end
  end

  // numerator and denominator
  always_comb begin
    v_ext    = {rdata_r[SAMPLE_W-1], rdata_r};
    d_ext    = v_ext - {min_r[SAMPLE_W-1], min_r};
    span_ext = {max_r[SAMPLE_W-1], max_r} - {min_r[SAMPLE_W-1], min_r};
    mag_ext  = v_ext[SAMPLE_W] ? -v_ext : v_ext;
    if (diff_mode_r) begin
      num_nxt = mag_ext[SAMPLE_W-1:0];
      den_nxt = (max_diff_r == '0) ? SAMPLE_W'(1) : max_diff_r;
    end else begin
      num_nxt = (d_ext > 0) ? d_ext[SAMPLE_W-1:0] : '0;
      den_nxt = (max_r > min_r) ? span_ext[SAMPLE_W-1:0] : SAMPLE_W'(1);
    end
  end

  // restoring divider, one quotient bit per step
  assign trial    = {rem_r, quo_r[GRAY_W-1]};
  assign trial_ge = (trial >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      num_r <= num_nxt;
      den_r <= den_nxt;
    end
    if (cmd.mul) begin
      prod_r <= (PROD_W'(num_r) << GRAY_W) - PROD_W'(num_r);
    end
    if (cmd.init) begin
      sat_r <= (prod_r >= {den_r, GRAY_W'(0)});
      rem_r <= (prod_r >= {den_r, GRAY_W'(0)}) ? '0 : prod_r[PROD_W-1:GRAY_W];
      quo_r <= prod_r[GRAY_W-1:0];
    end else if (cmd.step) begin
      rem_r <= trial_ge ? SAMPLE_W'(trial - {1'b0, den_r}) : trial[SAMPLE_W-1:0];
      quo_r <= {quo_r[GRAY_W-2:0], trial_ge};
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_gray_r <= sat_r ? GRAY_MAX : quo_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_gray  = out_gray_r;

  `SMMG_ASSERT_NOW(a_rem_below_den, cmd.step, rem_r < den_r, "divider remainder out of range")
  `SMMG_ASSERT_NOW(a_den_nonzero, cmd.init, den_r != '0, "zero divisor reached divider")
  `SMMG_ASSERT_NOW(a_no_overwrite, cmd.load_out, !out_valid_r || out_ready, "pending result overwritten")

endmodule

### hw/rtl/slice_min_max_gray_normalize.sv
// ----------------------------------------------------------------------------
// slice_min_max_gray_normalize
// min-max contrast stretch of a signed 16-bit slice to 8-bit gray
// ----------------------------------------------------------------------------
// Clear and load items leave the block idle, so it stays ready for the
// next item. A read item keeps the block busy from the accepting cycle
// until its result is handed over; no item is taken in between. The
// accepting cycle also reads the pixel store. After it come the states
// for the numerator and denominator, the multiply by 255, the overflow
// check, the one-bit-per-cycle restoring divider and the hand-over of
// the result to the output register. The hand-over stretches for as long
// as an earlier result still waits unaccepted in that register. The
// result waits in that register while further items are taken.
// Configuration writes are always ready. Pixels read before they were
// loaded return arbitrary gray values; the store has no reset.
module slice_min_max_gray_normalize import smmg_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 in_opcode,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  input  logic [COORD_W-1:0]         in_row,
  input  logic [COORD_W-1:0]         in_col,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [GRAY_W-1:0]          out_gray,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data
);

  smmg_cmd_t cmd;
  smmg_sts_t sts;

  assign cfg_ready = 1'b1;

  smmg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  smmg_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_opcode (in_opcode),
    .in_sample (in_sample),
    .in_row    (in_row),
    .in_col    (in_col),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_gray  (out_gray)
  );

endmodule

### bench/slice_min_max_gray_normalize_tb.sv
// ----------------------------------------------------------------------------
// slice_min_max_gray_normalize_tb
// Drives clear, load and read items into the gray normalize block under
// random sender gaps and receiver stalls. A built-in copy of the min-max
// and difference-mode stretch predicts each gray value, and every result
// is checked in order. A short list of fixed cases runs first, then
// randomized phases, each under a new register setting.
// ----------------------------------------------------------------------------
module slice_min_max_gray_normalize_tb import smmg_pkg::*; ();

  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam int         SETTLE_CYC  = 20;
  localparam int         CYCLE_LIMIT = 1000000;
  localparam int         PHASES      = 12;
  localparam int         PHASE_ITEMS = 125;

  typedef struct {
    bit          is_cfg;
    cfg_reg_t    reg_sel;
    logic [15:0] value;
    logic [1:0]  op;
    logic [8:0]  row;
    logic [8:0]  col;
    bit          typed;
    logic [7:0]  gray;
  } step_row_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic [1:0]                 in_opcode = OP_CLEAR;
  logic signed [SAMPLE_W-1:0] in_sample = '0;
  logic [COORD_W-1:0]         in_row = '0;
  logic [COORD_W-1:0]         in_col = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic [GRAY_W-1:0]          out_gray;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [CFG_IDX_W-1:0]       cfg_index = REG_IMAGE_WIDTH;
  logic [CFG_DATA_W-1:0]      cfg_data = '0;

  // predictor state
  logic [15:0] pixel_mem [int];
  int          written_q [$];
  int          lo_stat = 32767;
  int          hi_stat = -32768;
  logic [9:0]  width_r = WIDTH_RST;
  logic [9:0]  height_r = HEIGHT_RST;
  logic        diff_mode = 1'b0;
  logic [15:0] full_scale = MAX_DIFF_RST;

  logic [7:0]  gray_due [$];
  logic [7:0]  want_gray;
  step_row_t   script_q [$];
  int          errors = 0;
  int          cycle_cnt = 0;
  int          burst_left = 0;
  int          stall_left = 0;
  int          stall_mode = 0;

  slice_min_max_gray_normalize dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_opcode (in_opcode),
    .in_sample (in_sample),
    .in_row    (in_row),
    .in_col    (in_col),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_gray  (out_gray),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  function automatic int eff_w();
    return (width_r > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : int'(width_r);
  endfunction

  function automatic int eff_h();
    return (height_r > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : int'(height_r);
  endfunction

  function automatic logic [7:0] gray_level(int v);
    longint num, den, q;
    if (diff_mode) begin
      num = (v < 0) ? -v : v;
      den = (full_scale == 0) ? 1 : full_scale;
    end else begin
      if (v <= lo_stat) return '0;
      num = v - lo_stat;
      den = (hi_stat > lo_stat) ? hi_stat - lo_stat : 1;
    end
    q = num * 255 / den;
    return (q > 255) ? GRAY_MAX : q[7:0];
  endfunction

  function automatic bit stretch_step(input logic [1:0] op, input logic [15:0] smp,
                                      input logic [8:0] r, input logic [8:0] c,
                                      output logic [7:0] g);
    int w, h, s, a;
    w = eff_w();
    h = eff_h();
    s = $signed(smp);
    g = '0;
    if (op == OP_CLEAR) begin
      lo_stat = 32767;
      hi_stat = -32768;
      return 0;
    end
    if (op == OP_UNUSED || int'(r) >= h || int'(c) >= w) return 0;
    if (op == OP_LOAD) begin
      a = int'(r) * DEF_MAX_WIDTH + int'(c);
      if (!pixel_mem.exists(a)) written_q.push_back(a);
      pixel_mem[a] = smp;
      if (s < lo_stat) lo_stat = s;
      if (s > hi_stat) hi_stat = s;
      return 0;
    end
    g = gray_level($signed(pixel_mem[(h - 1 - int'(r)) * DEF_MAX_WIDTH + int'(c)]));
    return 1;
  endfunction

  function automatic void add_cfg(cfg_reg_t idx, logic [15:0] val);
    step_row_t s;
    s = '{1'b1, idx, val, OP_CLEAR, '0, '0, 1'b0, '0};
    script_q.push_back(s);
  endfunction

  function automatic void add_step(logic [1:0] op, logic [15:0] smp, int r, int c,
                                   bit typed = 1'b0, int g = 0);
    step_row_t s;
    s = '{1'b0, REG_IMAGE_WIDTH, smp, op, r[8:0], c[8:0], typed, g[7:0]};
    script_q.push_back(s);
  endfunction

  function automatic logic [15:0] pick_sample(logic [15:0] base);
    case ($urandom_range(0, 7))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2, 3, 4: return 16'($urandom);
      default: return base + 16'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic bit pick_written(output logic [8:0] r, output logic [8:0] c);
    int a, src, w, h, n;
    w = eff_w();
    h = eff_h();
    r = '0;
    c = '0;
    n = written_q.size();
    if (n == 0) return 0;
    for (int t = 0; t < 8; t++) begin
      if ($urandom_range(0, 1) && n > 32) a = written_q[n - 1 - $urandom_range(0, 31)];
      else a = written_q[$urandom_range(0, n - 1)];
      src = a / DEF_MAX_WIDTH;
      if (src < h && (a % DEF_MAX_WIDTH) < w) begin
        r = 9'(h - 1 - src);
        c = 9'(a % DEF_MAX_WIDTH);
        return 1;
      end
    end
    return 0;
  endfunction

  function automatic logic [9:0] pick_dim();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return 10'($urandom_range(1, 16));
      5:             return 10'd1;
      6:             return 10'd512;
      7:             return 10'($urandom_range(513, 1023));
      default:       return 10'($urandom_range(1, 512));
    endcase
  endfunction

  task automatic issue(logic [1:0] op, logic [15:0] smp, logic [8:0] r, logic [8:0] c,
                       bit typed, logic [7:0] typed_gray);
    logic [7:0] g;
    int gap;
    @(negedge clk);
    in_valid  <= 1'b1;
    in_opcode <= op;
    in_sample <= smp;
    in_row    <= r;
    in_col    <= c;
    do @(posedge clk); while (!in_ready);
    if (stretch_step(op, smp, r, c, g)) gray_due.push_back(typed ? typed_gray : g);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 40);
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // pause the sender until every result is back and the block is idle
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (gray_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_IMAGE_WIDTH:     width_r = val[9:0];
      REG_IMAGE_HEIGHT:    height_r = val[9:0];
      REG_DIFFERENCE_MODE: diff_mode = val[0];
      REG_MAX_DIFF:        full_scale = val;
      default:             ;
    endcase
  endtask

  // receiver stall pattern
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(16, 160);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= 1'($urandom_range(0, 1));
      2:       out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= ($urandom_range(0, 15) != 0);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (gray_due.size() == 0) begin
        $display("%0t: gray expected none, actual %0d", $time, out_gray);
        errors++;
      end else begin
        want_gray = gray_due.pop_front();
        if (out_gray !== want_gray) begin
          $display("%0t: gray expected %0d, actual %0d", $time, want_gray, out_gray);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results outstanding", $time, gray_due.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    bit          cfg_open;
    int          done, k, w, h;
    logic [1:0]  op;
    logic [8:0]  r, c;
    logic [15:0] base;

    // fixed cases, default 512 x 512 normal mode
    add_step(OP_LOAD, 16'h8000, 0, 0);
    add_step(OP_LOAD, 16'h7fff, 511, 511);
    add_step(OP_READ, 16'h0000, 511, 0, 1, 0);
    add_step(OP_READ, 16'hffff, 0, 511, 1, 255);
    add_step(OP_LOAD, 16'h0000, 5, 7);
    add_step(OP_READ, 16'h0000, 506, 7, 1, 127);
    add_step(OP_UNUSED, 16'hffff, 511, 511);
    add_step(OP_CLEAR, 16'h0000, 0, 0);
    add_step(OP_READ, 16'h0000, 0, 511, 1, 0);
    add_step(OP_LOAD, 16'd100, 1, 1);
    add_step(OP_READ, 16'h0000, 510, 1, 1, 0);
    add_step(OP_READ, 16'h0000, 0, 511, 1, 255);
    add_step(OP_LOAD, 16'd101, 2, 2);
    add_step(OP_READ, 16'h0000, 509, 2, 1, 255);
    add_step(OP_READ, 16'h0000, 511, 0);
    // small slice, difference mode, zero full scale
    add_cfg(REG_IMAGE_WIDTH, 16'hfc03);
    add_cfg(REG_IMAGE_HEIGHT, 16'd4);
    add_cfg(REG_DIFFERENCE_MODE, 16'd1);
    add_cfg(REG_MAX_DIFF, 16'd0);
    add_step(OP_READ, 16'h0000, 3, 0, 1, 255);
    add_step(OP_LOAD, 16'h0000, 0, 1);
    add_step(OP_READ, 16'h0000, 3, 1, 1, 0);
    add_step(OP_LOAD, 16'd7, 0, 3);
    add_step(OP_READ, 16'h0000, 4, 0);
    add_cfg(REG_MAX_DIFF, 16'hffff);
    add_step(OP_READ, 16'h0000, 3, 0, 1, 127);
    add_step(OP_READ, 16'h0000, 2, 1);
    // zero width ignores everything
    add_cfg(REG_IMAGE_WIDTH, 16'd0);
    add_step(OP_LOAD, 16'd5, 0, 0);
    add_step(OP_READ, 16'h0000, 0, 0);
    // oversized dimensions act as the maximum
    add_cfg(REG_IMAGE_WIDTH, 16'd1023);
    add_cfg(REG_IMAGE_HEIGHT, 16'd1023);
    add_cfg(REG_DIFFERENCE_MODE, 16'd0);
    add_cfg(REG_MAX_DIFF, 16'h5a5a);
    add_step(OP_READ, 16'h0000, 0, 511);
    add_step(OP_READ, 16'h0000, 511, 0);

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    cfg_open = 1'b0;
    foreach (script_q[i]) begin
      if (script_q[i].is_cfg) begin
        if (!cfg_open) settle();
        write_reg(script_q[i].reg_sel, script_q[i].value);
        cfg_open = 1'b1;
      end else begin
        if (cfg_open) begin
          @(negedge clk);
          cfg_valid <= 1'b0;
          cfg_open = 1'b0;
        end
        issue(script_q[i].op, script_q[i].value, script_q[i].row, script_q[i].col,
              script_q[i].typed, script_q[i].gray);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      settle();
      write_reg(REG_IMAGE_WIDTH, {6'($urandom), pick_dim()});
      write_reg(REG_IMAGE_HEIGHT, {6'($urandom), pick_dim()});
      write_reg(REG_DIFFERENCE_MODE, {15'($urandom), 1'($urandom_range(0, 1))});
      case ($urandom_range(0, 5))
        0:       write_reg(REG_MAX_DIFF, 16'd0);
        1:       write_reg(REG_MAX_DIFF, 16'hffff);
        2:       write_reg(REG_MAX_DIFF, 16'd1);
        3:       write_reg(REG_MAX_DIFF, 16'($urandom));
        default: write_reg(REG_MAX_DIFF, 16'($urandom_range(1, 2000)));
      endcase
      @(negedge clk);
      cfg_valid <= 1'b0;
      w = eff_w();
      h = eff_h();
      base = 16'($urandom);
      if ($urandom_range(0, 1)) issue(OP_CLEAR, 16'($urandom), 9'($urandom), 9'($urandom),
                                      1'b0, '0);
      done = 0;
      while (done < PHASE_ITEMS) begin
        if (done == 60) settle();
        k = $urandom_range(0, 99);
        if (k < 2) begin
          issue(OP_CLEAR, 16'($urandom), 9'($urandom), 9'($urandom), 1'b0, '0);
          done++;
        end else if (k < 4) begin
          issue(OP_UNUSED, 16'($urandom), 9'($urandom), 9'($urandom), 1'b0, '0);
        end else if (k < 8) begin
          // noise: any coordinates, mostly out of range on small slices
          op = $urandom_range(0, 1) ? OP_READ : OP_LOAD;
          r = 9'($urandom);
          c = 9'($urandom);
          if (op == OP_READ && int'(r) < h && int'(c) < w &&
              !pixel_mem.exists((h - 1 - int'(r)) * DEF_MAX_WIDTH + int'(c)))
            op = OP_LOAD;
          issue(op, pick_sample(base), r, c, 1'b0, '0);
        end else if (k < 50 || !pick_written(r, c)) begin
          issue(OP_LOAD, pick_sample(base), 9'($urandom_range(0, h - 1)),
                9'($urandom_range(0, w - 1)), 1'b0, '0);
          done++;
        end else begin
          issue(OP_READ, 16'($urandom), r, c, 1'b0, '0);
          done++;
        end
      end
    end

    settle();
    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
